// File: rtl/ccp_pkg.sv
// Shared types, constants and microcode encodings for the column crack partition block.
`timescale 1ns / 1ps
`default_nettype none

package ccp_pkg;

  localparam int ROWS    = 1024;
  localparam int COLUMNS = 2;
  localparam int ROW_W   = $clog2(ROWS);
  localparam int COL_W   = 1;
  localparam int PTR_W   = $clog2(ROWS + 1);
  localparam int DATA_W  = 32;
  localparam int CMD_W   = 2;
  localparam int STEP_W  = 5;

  // Input word layout, lowest bit first.
  localparam int OFF_ROW = 0;
  localparam int OFF_COL = OFF_ROW + ROW_W;
  localparam int OFF_MIN = OFF_COL + COL_W;
  localparam int OFF_MAX = OFF_MIN + DATA_W;
  localparam int OFF_LO  = OFF_MAX + DATA_W;
  localparam int OFF_HI  = OFF_LO + PTR_W;
  localparam int OFF_KL  = OFF_HI + PTR_W;
  localparam int OFF_KR  = OFF_KL + DATA_W;
  localparam int IN_BITS = OFF_KR + DATA_W;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

  // Output word layout, lowest bit first.
  localparam int OFF_S1   = 0;
  localparam int OFF_S2   = OFF_S1 + PTR_W;
  localparam int OFF_RMIN = OFF_S2 + PTR_W;
  localparam int OFF_RMAX = OFF_RMIN + DATA_W;
  localparam int OUT_BITS = OFF_RMAX + DATA_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CRACK2 = 2'd2,
    CMD_CRACK3 = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] maxv;
    logic [DATA_W-1:0] minv;
  } entry_t;

  typedef entry_t [COLUMNS-1:0] row_t;

  typedef enum logic [1:0] {
    RD_NONE  = 2'd0,
    RD_LEFT  = 2'd1,
    RD_RIGHT = 2'd2,
    RD_ROW   = 2'd3
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE   = 2'd0,
    WR_ENTRY  = 2'd1,
    WR_SWAP_A = 2'd2,
    WR_SWAP_B = 2'd3
  } wr_sel_t;

  typedef enum logic [3:0] {
    OP_NONE    = 4'd0,
    OP_INIT1   = 4'd1,
    OP_INIT2   = 4'd2,
    OP_CAP_L   = 4'd3,
    OP_CAP_R   = 4'd4,
    OP_INC_L   = 4'd5,
    OP_DEC_R   = 4'd6,
    OP_INC_DEC = 4'd7,
    OP_SAVE    = 4'd8
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER       = 3'd0,
    C_ALWAYS      = 3'd1,
    C_OUTER_DONE  = 3'd2,
    C_LESS        = 3'd3,
    C_INNER_STOP  = 3'd4,
    C_NO_SWAP     = 3'd5,
    C_PASS2       = 3'd6
  } cond_t;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t ST_IDLE     = 5'd0;
  localparam step_t ST_WRITE    = 5'd1;
  localparam step_t ST_READ     = 5'd2;
  localparam step_t ST_READ_OUT = 5'd3;
  localparam step_t ST_CRACK    = 5'd4;
  localparam step_t ST_OUTER    = 5'd5;
  localparam step_t ST_TEST_L   = 5'd6;
  localparam step_t ST_INNER    = 5'd7;
  localparam step_t ST_TEST_R   = 5'd8;
  localparam step_t ST_DEC      = 5'd9;
  localparam step_t ST_SWAP_CHK = 5'd10;
  localparam step_t ST_SWAP_A   = 5'd11;
  localparam step_t ST_SWAP_B   = 5'd12;
  localparam step_t ST_STEP_INC = 5'd13;
  localparam step_t ST_PASS_END = 5'd14;
  localparam step_t ST_FINISH   = 5'd15;
  localparam step_t ST_CRACK2   = 5'd16;

  typedef struct packed {
    rd_sel_t rd;
    wr_sel_t wr;
    op_t     op;
    cond_t   cond;
    logic    fin;
    step_t   target;
  } ucode_t;

  typedef struct packed {
    rd_sel_t rd;
    wr_sel_t wr;
    op_t     op;
    logic    fin;
    logic    go;
    logic    accept;
  } ctrl_t;

  typedef struct packed {
    logic outer_done;
    logic less;
    logic inner_stop;
    logic no_swap;
    logic pass2;
  } flags_t;

endpackage

`default_nettype wire

// File: rtl/ccp_row_ram.sv
// Row-wide table memory with a write enable per column and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ccp_row_ram (
  input  wire logic                      clk,
  input  wire logic [ccp_pkg::COLUMNS-1:0] we,
  input  wire logic [ccp_pkg::ROW_W-1:0]   waddr,
  input  wire ccp_pkg::row_t               wdata,
  input  wire logic                      re,
  input  wire logic [ccp_pkg::ROW_W-1:0]   raddr,
  output ccp_pkg::row_t                    rdata
);

  ccp_pkg::entry_t mem [ccp_pkg::ROWS][ccp_pkg::COLUMNS];

  always_ff @(posedge clk) begin
    for (int c = 0; c < ccp_pkg::COLUMNS; c++) begin
      if (we[c]) begin
        mem[waddr][c] <= wdata[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      for (int c = 0; c < ccp_pkg::COLUMNS; c++) begin
        rdata[c] <= mem[raddr][c];
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/ccp_sequencer.sv
// Microcode store and step counter that steer the partition datapath.
`timescale 1ns / 1ps
`default_nettype none

module ccp_sequencer (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire ccp_pkg::cmd_t   cmd,
  input  wire ccp_pkg::flags_t flags,
  input  wire logic            out_free,
  output logic                 ready,
  output ccp_pkg::ctrl_t       ctrl
);

  ccp_pkg::step_t  pc;
  ccp_pkg::step_t  pc_next;
  ccp_pkg::step_t  entry;
  ccp_pkg::ucode_t cw;
  logic            idle;
  logic            go;
  logic            cond_true;

  // Control store: one word per step.
  always_comb begin
    cw = '{rd: ccp_pkg::RD_NONE, wr: ccp_pkg::WR_NONE, op: ccp_pkg::OP_NONE,
           cond: ccp_pkg::C_NEVER, fin: 1'b0, target: ccp_pkg::ST_IDLE};
    case (pc)
      ccp_pkg::ST_WRITE: begin
        cw.wr = ccp_pkg::WR_ENTRY;
        cw.cond = ccp_pkg::C_ALWAYS;
        cw.fin = 1'b1;
      end
      ccp_pkg::ST_READ: begin
        cw.rd = ccp_pkg::RD_ROW;
      end
      ccp_pkg::ST_READ_OUT: begin
        cw.cond = ccp_pkg::C_ALWAYS;
        cw.fin = 1'b1;
      end
      ccp_pkg::ST_CRACK: begin
        cw.op = ccp_pkg::OP_INIT1;
      end
      ccp_pkg::ST_OUTER: begin
        cw.rd = ccp_pkg::RD_LEFT;
        cw.cond = ccp_pkg::C_OUTER_DONE;
        cw.target = ccp_pkg::ST_PASS_END;
      end
      ccp_pkg::ST_TEST_L: begin
        cw.op = ccp_pkg::OP_CAP_L;
        cw.cond = ccp_pkg::C_LESS;
        cw.target = ccp_pkg::ST_STEP_INC;
      end
      ccp_pkg::ST_INNER: begin
        cw.rd = ccp_pkg::RD_RIGHT;
        cw.cond = ccp_pkg::C_INNER_STOP;
        cw.target = ccp_pkg::ST_SWAP_CHK;
      end
      ccp_pkg::ST_TEST_R: begin
        cw.op = ccp_pkg::OP_CAP_R;
        cw.cond = ccp_pkg::C_LESS;
        cw.target = ccp_pkg::ST_SWAP_CHK;
      end
      ccp_pkg::ST_DEC: begin
        cw.op = ccp_pkg::OP_DEC_R;
        cw.cond = ccp_pkg::C_ALWAYS;
        cw.target = ccp_pkg::ST_INNER;
      end
      ccp_pkg::ST_SWAP_CHK: begin
        cw.cond = ccp_pkg::C_NO_SWAP;
        cw.target = ccp_pkg::ST_OUTER;
      end
      ccp_pkg::ST_SWAP_A: begin
        cw.wr = ccp_pkg::WR_SWAP_A;
      end
      ccp_pkg::ST_SWAP_B: begin
        cw.wr = ccp_pkg::WR_SWAP_B;
        cw.op = ccp_pkg::OP_INC_DEC;
        cw.cond = ccp_pkg::C_ALWAYS;
        cw.target = ccp_pkg::ST_OUTER;
      end
      ccp_pkg::ST_STEP_INC: begin
        cw.op = ccp_pkg::OP_INC_L;
        cw.cond = ccp_pkg::C_ALWAYS;
        cw.target = ccp_pkg::ST_OUTER;
      end
      ccp_pkg::ST_PASS_END: begin
        cw.op = ccp_pkg::OP_SAVE;
        cw.cond = ccp_pkg::C_PASS2;
        cw.target = ccp_pkg::ST_CRACK2;
      end
      ccp_pkg::ST_FINISH: begin
        cw.cond = ccp_pkg::C_ALWAYS;
        cw.fin = 1'b1;
      end
      ccp_pkg::ST_CRACK2: begin
        cw.op = ccp_pkg::OP_INIT2;
        cw.cond = ccp_pkg::C_ALWAYS;
        cw.target = ccp_pkg::ST_OUTER;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (cw.cond)
      ccp_pkg::C_ALWAYS:     cond_true = 1'b1;
      ccp_pkg::C_OUTER_DONE: cond_true = flags.outer_done;
      ccp_pkg::C_LESS:       cond_true = flags.less;
      ccp_pkg::C_INNER_STOP: cond_true = flags.inner_stop;
      ccp_pkg::C_NO_SWAP:    cond_true = flags.no_swap;
      ccp_pkg::C_PASS2:      cond_true = flags.pass2;
      default:               cond_true = 1'b0;
    endcase
  end

  always_comb begin
    case (cmd)
      ccp_pkg::CMD_WRITE: entry = ccp_pkg::ST_WRITE;
      ccp_pkg::CMD_READ:  entry = ccp_pkg::ST_READ;
      default:            entry = ccp_pkg::ST_CRACK;
    endcase
  end

  assign idle  = (pc == ccp_pkg::ST_IDLE);
  assign ready = idle;
  // A final step waits here until the output register can take the result.
  assign go    = !(cw.fin && !out_free);

  always_comb begin
    if (idle) begin
      pc_next = in_valid ? entry : ccp_pkg::ST_IDLE;
    end else if (!go) begin
      pc_next = pc;
    end else if (cond_true) begin
      pc_next = cw.target;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ccp_pkg::ST_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  assign ctrl = '{rd: cw.rd, wr: cw.wr, op: cw.op, fin: cw.fin, go: go,
                  accept: idle && in_valid};

endmodule

`default_nettype wire

// File: rtl/ccp_datapath.sv
// Pointer registers, key compare, row buffers, table memory and output register.
`timescale 1ns / 1ps
`default_nettype none

module ccp_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic [ccp_pkg::IN_TDATA_W-1:0]   in_data,
  input  wire ccp_pkg::cmd_t                    in_cmd,
  input  wire ccp_pkg::ctrl_t                   ctrl,
  output ccp_pkg::flags_t                       flags,
  output logic                                  out_free,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [ccp_pkg::OUT_TDATA_W-1:0]       out_data
);

  localparam logic [ccp_pkg::PTR_W-1:0] ROWS_P = ccp_pkg::PTR_W'(ccp_pkg::ROWS);

  ccp_pkg::cmd_t                 cmd;
  logic [ccp_pkg::ROW_W-1:0]     row;
  logic [ccp_pkg::COL_W-1:0]     col;
  logic [ccp_pkg::DATA_W-1:0]    wmin;
  logic [ccp_pkg::DATA_W-1:0]    wmax;
  logic [ccp_pkg::PTR_W-1:0]     lo;
  logic [ccp_pkg::PTR_W-1:0]     hi;
  logic [ccp_pkg::DATA_W-1:0]    key_lo;
  logic [ccp_pkg::DATA_W-1:0]    key_hi;

  // rp1 holds the right pointer plus one, so an empty range needs no sign bit.
  logic [ccp_pkg::PTR_W-1:0]     left;
  logic [ccp_pkg::PTR_W-1:0]     rp1;
  logic [ccp_pkg::PTR_W-1:0]     rp1_m1;
  logic [ccp_pkg::PTR_W:0]       left_p1;
  logic                          pass;
  logic [ccp_pkg::PTR_W-1:0]     s1;
  logic [ccp_pkg::PTR_W-1:0]     s2;
  ccp_pkg::row_t                 data_l;
  ccp_pkg::row_t                 data_r;

  logic [ccp_pkg::PTR_W-1:0]     lo_in;
  logic [ccp_pkg::PTR_W-1:0]     hi_in;
  logic [ccp_pkg::DATA_W-1:0]    key;
  ccp_pkg::entry_t               rd_entry;

  logic [ccp_pkg::COLUMNS-1:0]   we;
  logic [ccp_pkg::ROW_W-1:0]     waddr;
  ccp_pkg::row_t                 wdata;
  logic                          re;
  logic [ccp_pkg::ROW_W-1:0]     raddr;
  ccp_pkg::row_t                 rdata;

  logic [ccp_pkg::PTR_W-1:0]     res_s1;
  logic [ccp_pkg::PTR_W-1:0]     res_s2;
  logic [ccp_pkg::DATA_W-1:0]    res_min;
  logic [ccp_pkg::DATA_W-1:0]    res_max;

  assign lo_in = in_data[ccp_pkg::OFF_LO +: ccp_pkg::PTR_W];
  assign hi_in = in_data[ccp_pkg::OFF_HI +: ccp_pkg::PTR_W];

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      cmd    <= in_cmd;
      row    <= in_data[ccp_pkg::OFF_ROW +: ccp_pkg::ROW_W];
      col    <= in_data[ccp_pkg::OFF_COL +: ccp_pkg::COL_W];
      wmin   <= in_data[ccp_pkg::OFF_MIN +: ccp_pkg::DATA_W];
      wmax   <= in_data[ccp_pkg::OFF_MAX +: ccp_pkg::DATA_W];
      lo     <= (lo_in > ROWS_P) ? ROWS_P : lo_in;
      hi     <= (hi_in > ROWS_P) ? ROWS_P : hi_in;
      key_lo <= in_data[ccp_pkg::OFF_KL +: ccp_pkg::DATA_W];
      key_hi <= in_data[ccp_pkg::OFF_KR +: ccp_pkg::DATA_W];
    end
  end

  assign key      = pass ? key_hi : key_lo;
  assign rd_entry = rdata[col];
  assign rp1_m1   = rp1 - 1'b1;
  assign left_p1  = {1'b0, left} + 1'b1;

  assign flags.outer_done = !((left < rp1) && (rp1 > ccp_pkg::PTR_W'(1)));
  assign flags.less       = $signed(rd_entry.minv) < $signed(key);
  assign flags.inner_stop = !((rp1 > ccp_pkg::PTR_W'(1)) && (rp1 > left));
  assign flags.no_swap    = !(left_p1 < {1'b0, rp1});
  assign flags.pass2      = (cmd == ccp_pkg::CMD_CRACK3) && !pass;

  always_ff @(posedge clk) begin
    if (ctrl.go) begin
      case (ctrl.op)
        ccp_pkg::OP_INIT1: begin
          left <= lo;
          rp1  <= hi;
          pass <= 1'b0;
        end
        ccp_pkg::OP_INIT2: begin
          rp1  <= hi;
          pass <= 1'b1;
        end
        ccp_pkg::OP_CAP_L: data_l <= rdata;
        ccp_pkg::OP_CAP_R: data_r <= rdata;
        ccp_pkg::OP_INC_L: left <= left + 1'b1;
        ccp_pkg::OP_DEC_R: rp1 <= rp1_m1;
        ccp_pkg::OP_INC_DEC: begin
          left <= left + 1'b1;
          rp1  <= rp1_m1;
        end
        ccp_pkg::OP_SAVE: begin
          if (!pass) begin
            s1 <= left;
          end
          s2 <= left;
        end
        default: begin
        end
      endcase
    end
  end

  // A swap moves whole rows: the held right row goes to the left slot, then the reverse.
  always_comb begin
    we    = '0;
    waddr = row;
    wdata = data_r;
    case (ctrl.wr)
      ccp_pkg::WR_ENTRY: begin
        we[col] = ctrl.go;
        for (int c = 0; c < ccp_pkg::COLUMNS; c++) begin
          wdata[c] = '{maxv: wmax, minv: wmin};
        end
      end
      ccp_pkg::WR_SWAP_A: begin
        we    = {ccp_pkg::COLUMNS{ctrl.go}};
        waddr = left[ccp_pkg::ROW_W-1:0];
        wdata = data_r;
      end
      ccp_pkg::WR_SWAP_B: begin
        we    = {ccp_pkg::COLUMNS{ctrl.go}};
        waddr = rp1_m1[ccp_pkg::ROW_W-1:0];
        wdata = data_l;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (ctrl.rd)
      ccp_pkg::RD_LEFT:  raddr = left[ccp_pkg::ROW_W-1:0];
      ccp_pkg::RD_RIGHT: raddr = rp1_m1[ccp_pkg::ROW_W-1:0];
      default:           raddr = row;
    endcase
  end

  assign re = (ctrl.rd != ccp_pkg::RD_NONE) && ctrl.go;

  ccp_row_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    res_s1  = '0;
    res_s2  = '0;
    res_min = '0;
    res_max = '0;
    case (cmd)
      ccp_pkg::CMD_READ: begin
        res_min = rd_entry.minv;
        res_max = rd_entry.maxv;
      end
      ccp_pkg::CMD_CRACK2, ccp_pkg::CMD_CRACK3: begin
        res_s1 = s1;
        res_s2 = s2;
      end
      default: begin
      end
    endcase
  end

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.fin && ctrl.go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fin && ctrl.go) begin
      out_data <= {(ccp_pkg::OUT_TDATA_W - ccp_pkg::OUT_BITS)'(0),
                   res_max, res_min, res_s2, res_s1};
    end
  end

endmodule

`default_nettype wire

// File: rtl/column_crack_partition.sv
// A write posts its result from its write step, and a read from the output step that follows
// its read step. A crack starts with an init step; each pass steps pointers past rows, tests
// rows, stops at bounds, checks for and makes swaps and then saves its split; crack in three
// adds an init step between passes, and a crack ends with a step that posts its result.
// One word is in work at a time: the next is taken once the result is posted,
// which waits while the output register is full; reset clears the step counter and valid.
`timescale 1ns / 1ps
`default_nettype none

module column_crack_partition (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // row, column, min_value, max_value, range_low, range_high, key_lo, key_hi
  input  wire logic [ccp_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // cmd
  input  wire logic [ccp_pkg::CMD_W-1:0]      s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // first_split, second_split, read_min, read_max
  output logic [ccp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

  ccp_pkg::ctrl_t  ctrl;
  ccp_pkg::flags_t flags;
  ccp_pkg::cmd_t   in_cmd;
  logic            out_free;

  assign in_cmd = ccp_pkg::cmd_t'(s_axis_tuser);

  ccp_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .cmd      (in_cmd),
    .flags    (flags),
    .out_free (out_free),
    .ready    (s_axis_tready),
    .ctrl     (ctrl)
  );

  ccp_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_axis_tdata),
    .in_cmd    (in_cmd),
    .ctrl      (ctrl),
    .flags     (flags),
    .out_free  (out_free),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

`ifndef NO_ASSERTIONS
  // Only one word is in work at a time.
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second word taken while the sequencer was busy");

  // A result appears only from a final microcode step.
  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(ctrl.fin && ctrl.go))
    else $error("output valid rose without a final step");

  // The table memory never reads and writes in the same step.
  a_port_exclusive: assert property (@(posedge clk) disable iff (rst)
    !((ctrl.wr != ccp_pkg::WR_NONE) && (ctrl.rd != ccp_pkg::RD_NONE)))
    else $error("table read and write issued together");

  // The sequencer stalls only on a final step facing a full output register.
  a_stall_reason: assert property (@(posedge clk) disable iff (rst)
    !ctrl.go |-> ctrl.fin && m_axis_tvalid && !m_axis_tready)
    else $error("sequencer stalled without a blocked result");
`endif

endmodule

`default_nettype wire

// File: test/tb_column_crack_partition.sv
// Self-checking testbench for the column crack partition block, with a shadow table.
`timescale 1ns / 1ps
`default_nettype none

module tb_column_crack_partition;
  import ccp_pkg::*;

  localparam int PTR_MAX         = (1 << PTR_W) - 1;
  localparam int TARGET_WORDS    = 570;
  localparam int HOLD_OFF_CYCLES = 300;
  // The slowest legal crack in three over 96 rows and the long hold-off both
  // fall far inside this limit, so it leaves a wide margin.
  localparam int STALL_LIMIT     = 20000;
  localparam int MAX_REPORTS     = 10;
  localparam logic [DATA_W-1:0] MOST_NEG = 32'h8000_0000;
  localparam logic [DATA_W-1:0] MOST_POS = 32'h7fff_ffff;

  typedef struct packed {
    cmd_t              op;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [DATA_W-1:0] minv;
    logic [DATA_W-1:0] maxv;
    logic [PTR_W-1:0]  lo;
    logic [PTR_W-1:0]  hi;
    logic [DATA_W-1:0] key_lo;
    logic [DATA_W-1:0] key_hi;
  } crack_cmd_t;

  typedef struct packed {
    logic [PTR_W-1:0]  first;
    logic [PTR_W-1:0]  second;
    logic [DATA_W-1:0] rd_min;
    logic [DATA_W-1:0] rd_max;
  } split_t;

  class crack_shadow;
    logic [DATA_W-1:0] min_tab [ROWS][COLUMNS];
    logic [DATA_W-1:0] max_tab [ROWS][COLUMNS];
    bit                filled  [ROWS][COLUMNS];
    split_t            pending_splits [$];
    int                mismatches;

    // A swap moves whole rows, so the written marks travel with the data.
    function void swap_rows(int a, int b);
      logic [DATA_W-1:0] t;
      bit f;
      for (int c = 0; c < COLUMNS; c++) begin
        t = min_tab[a][c]; min_tab[a][c] = min_tab[b][c]; min_tab[b][c] = t;
        t = max_tab[a][c]; max_tab[a][c] = max_tab[b][c]; max_tab[b][c] = t;
        f = filled[a][c];  filled[a][c]  = filled[b][c];  filled[b][c]  = f;
      end
    endfunction

    // Two-pointer partition; the right pointer is never stepped below row 0.
    function int crack_range(int lo, int hi, logic [DATA_W-1:0] key, int c);
      int left;
      int right;
      left  = lo;
      right = hi - 1;
      while (left <= right && right > 0) begin
        if ($signed(min_tab[left][c]) < $signed(key)) begin
          left++;
        end else begin
          while (right > 0 && right >= left &&
                 !($signed(min_tab[right][c]) < $signed(key)))
            right--;
          if (left < right) begin
            if (left != right) swap_rows(left, right);
            left++;
            right--;
          end
        end
      end
      return left;
    endfunction

    function bit range_filled(int c, int lo, int hi);
      int top;
      top = (hi > ROWS) ? ROWS : hi;
      for (int r = lo; r < top; r++)
        if (!filled[r][c]) return 1'b0;
      return 1'b1;
    endfunction

    function void note_command(crack_cmd_t t);
      split_t s;
      int lo;
      int hi;
      s  = '0;
      lo = (int'(t.lo) > ROWS) ? ROWS : int'(t.lo);
      hi = (int'(t.hi) > ROWS) ? ROWS : int'(t.hi);
      case (t.op)
        CMD_WRITE: begin
          min_tab[t.row][t.col] = t.minv;
          max_tab[t.row][t.col] = t.maxv;
          filled[t.row][t.col]  = 1'b1;
        end
        CMD_READ: begin
          s.rd_min = min_tab[t.row][t.col];
          s.rd_max = max_tab[t.row][t.col];
        end
        CMD_CRACK2: begin
          s.first  = PTR_W'(crack_range(lo, hi, t.key_lo, int'(t.col)));
          s.second = s.first;
        end
        default: begin
          s.first  = PTR_W'(crack_range(lo, hi, t.key_lo, int'(t.col)));
          s.second = PTR_W'(crack_range(int'(s.first), hi, t.key_hi, int'(t.col)));
        end
      endcase
      pending_splits.push_back(s);
    endfunction

    function void check_response(logic [OUT_TDATA_W-1:0] word);
      split_t got;
      split_t want;
      got.first  = word[OFF_S1 +: PTR_W];
      got.second = word[OFF_S2 +: PTR_W];
      got.rd_min = word[OFF_RMIN +: DATA_W];
      got.rd_max = word[OFF_RMAX +: DATA_W];
      if (pending_splits.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result word %h", word);
        return;
      end
      want = pending_splits.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"mismatch: expected first=%0d second=%0d min=%h max=%h,",
                    " got first=%0d second=%0d min=%h max=%h"},
                   want.first, want.second, want.rd_min, want.rd_max,
                   got.first, got.second, got.rd_min, got.rd_max);
      end
    endfunction
  endclass

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [CMD_W-1:0]       s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  crack_shadow shadow = new();
  int          words_sent  = 0;
  int          burst_left  = 0;
  int          idle_cycles = 0;
  bit          steady      = 1'b0;
  bit          hold_req    = 1'b0;

  always #4 clk = ~clk;

  column_crack_partition u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  function automatic logic [IN_TDATA_W-1:0] pack_word(crack_cmd_t t);
    logic [IN_TDATA_W-1:0] w;
    w = '0;
    w[OFF_ROW +: ROW_W]  = t.row;
    w[OFF_COL +: COL_W]  = t.col;
    w[OFF_MIN +: DATA_W] = t.minv;
    w[OFF_MAX +: DATA_W] = t.maxv;
    w[OFF_LO +: PTR_W]   = t.lo;
    w[OFF_HI +: PTR_W]   = t.hi;
    w[OFF_KL +: DATA_W]  = t.key_lo;
    w[OFF_KR +: DATA_W]  = t.key_hi;
    return w;
  endfunction

  // Values cluster around a centre so that keys land among the stored values.
  function automatic logic [DATA_W-1:0] near_value(logic [DATA_W-1:0] centre);
    case ($urandom_range(0, 11))
      0:       return MOST_NEG;
      1:       return MOST_POS;
      2:       return '0;
      3:       return '1;
      4:       return $urandom;
      default: return centre + $urandom_range(0, 15) - 8;
    endcase
  endfunction

  task automatic issue(cmd_t op, int row, int col, logic [DATA_W-1:0] minv,
                       logic [DATA_W-1:0] maxv, int lo, int hi,
                       logic [DATA_W-1:0] key_lo, logic [DATA_W-1:0] key_hi);
    crack_cmd_t t;
    t.op     = op;
    t.row    = ROW_W'(row);
    t.col    = COL_W'(col);
    t.minv   = minv;
    t.maxv   = maxv;
    t.lo     = PTR_W'(lo);
    t.hi     = PTR_W'(hi);
    t.key_lo = key_lo;
    t.key_hi = key_hi;
    if (!steady && burst_left <= 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_word(t);
    s_axis_tuser  <= t.op;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    shadow.note_command(t);
    words_sent++;
    burst_left--;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (shadow.pending_splits.size() != 0);
  endtask

  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready)
      shadow.check_response(m_axis_tdata);
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("column_crack_partition regression: fail");
        $finish;
      end
    end
  end

  // Receiver: rotates through stall patterns and takes one long hold-off on request.
  initial begin : receiver
    int rcyc;
    int hold_left;
    bit hold_taken;
    rcyc       = 0;
    hold_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      rcyc++;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_OFF_CYCLES - 1;
        m_axis_tready <= 1'b0;
      end else begin
        case ((rcyc / 256) % 4)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          2:       m_axis_tready <= ((rcyc % 7) < 4);
          default: m_axis_tready <= $urandom_range(0, 1);
        endcase
      end
    end
  end

  initial begin : stimulus
    int base;
    int span;
    int c;
    int lo;
    int hi;
    int r;
    int rc;
    int pick;
    int episode;
    logic [DATA_W-1:0] centre;
    logic [DATA_W-1:0] ka;
    logic [DATA_W-1:0] kb;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Extremes written at the bottom of column 0, and small values at the top of column 1.
    issue(CMD_WRITE, 0, 0, MOST_NEG, MOST_POS, 0, 0, '0, '0);
    issue(CMD_WRITE, 1, 0, MOST_POS, MOST_NEG, 0, 0, '0, '0);
    issue(CMD_WRITE, 2, 0, '0, '1, 0, 0, '0, '0);
    issue(CMD_WRITE, 3, 0, '1, '0, 0, 0, '0, '0);
    issue(CMD_WRITE, ROWS - 4, 1, 32'd0, 32'd7, 0, 0, '0, '0);
    issue(CMD_WRITE, ROWS - 3, 1, -32'sd5, 32'd1, 0, 0, '0, '0);
    issue(CMD_WRITE, ROWS - 2, 1, 32'd5, 32'd2, 0, 0, '0, '0);
    issue(CMD_WRITE, ROWS - 1, 1, 32'd9, 32'd3, 0, 0, '0, '0);
    issue(CMD_READ, 0, 0, '0, '0, 0, 0, '0, '0);
    issue(CMD_READ, ROWS - 1, 1, '0, '0, 0, 0, '0, '0);
    // Ranges starting at row 0 hit the floor of the right pointer.
    issue(CMD_CRACK2, 0, 0, '0, '0, 0, 4, '0, '0);
    issue(CMD_CRACK3, 0, 0, '0, '0, 0, 4, '1, 32'd1);
    // Upper key below the lower one.
    issue(CMD_CRACK3, 0, 0, '0, '0, 0, 4, 32'd100, -32'sd100);
    // Upper bound clamped to the table size.
    issue(CMD_CRACK2, 0, 1, '0, '0, ROWS - 4, PTR_MAX, 32'd3, '0);
    issue(CMD_CRACK3, 0, 1, '0, '0, ROWS - 4, ROWS, MOST_NEG, MOST_POS);
    // Empty and reversed ranges move nothing.
    issue(CMD_CRACK2, 0, 0, '0, '0, PTR_MAX, PTR_MAX, '0, '0);
    issue(CMD_CRACK3, 0, 0, '0, '0, 1500, 3, '0, '0);
    issue(CMD_CRACK2, 0, 0, '0, '0, 2, 2, '0, '0);
    for (r = 0; r < 4; r++) begin
      issue(CMD_READ, r, 0, '0, '0, 0, 0, '0, '0);
      issue(CMD_READ, ROWS - 4 + r, 1, '0, '0, 0, 0, '0, '0);
    end
    drain();

    // Each episode fills a window of one column, then cracks and reads it.
    episode = 0;
    while (words_sent < TARGET_WORDS) begin
      episode++;
      steady = (episode % 5 == 3);
      if (episode == 6) hold_req = 1'b1;
      if (episode == 18) drain();
      c    = $urandom_range(0, COLUMNS - 1);
      pick = $urandom_range(0, 19);
      if (pick < 16)
        span = $urandom_range(2, 16);
      else if (pick < 19)
        span = $urandom_range(17, 48);
      else
        span = $urandom_range(49, 96);
      case ($urandom_range(0, 4))
        0:       base = 0;
        1:       base = ROWS - span;
        default: base = $urandom_range(0, ROWS - span);
      endcase
      centre = $urandom;
      for (r = base; r < base + span; r++) begin
        issue(CMD_WRITE, r, c, near_value(centre), $urandom, $urandom_range(0, PTR_MAX),
              $urandom_range(0, PTR_MAX), $urandom, $urandom);
        if ($urandom_range(0, 3) == 0)
          issue(CMD_WRITE, r, 1 - c, near_value(centre), $urandom, 0, 0, $urandom, $urandom);
      end
      repeat ($urandom_range(2, 8)) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          if ($urandom_range(0, 2) == 0) begin
            lo = base;
            hi = base + span;
          end else begin
            lo = $urandom_range(base, base + span - 1);
            hi = $urandom_range(lo + 1, base + span);
          end
          if (hi == ROWS && $urandom_range(0, 1) == 1) hi = $urandom_range(ROWS, PTR_MAX);
          ka = near_value(centre);
          kb = near_value(centre);
          if ($urandom_range(0, 3) != 0 && $signed(kb) < $signed(ka)) begin
            ka = ka ^ kb;
            kb = ka ^ kb;
            ka = ka ^ kb;
          end
          if (shadow.range_filled(c, lo, hi))
            issue(($urandom_range(0, 1) == 1) ? CMD_CRACK3 : CMD_CRACK2,
                  $urandom_range(0, ROWS - 1), c, $urandom, $urandom, lo, hi, ka, kb);
        end else if (pick < 8) begin
          r  = $urandom_range(base, base + span - 1);
          rc = $urandom_range(0, COLUMNS - 1);
          if (!shadow.filled[r][rc]) rc = c;
          issue(CMD_READ, r, rc, $urandom, $urandom, $urandom_range(0, PTR_MAX),
                $urandom_range(0, PTR_MAX), $urandom, $urandom);
        end else begin
          lo = $urandom_range(0, PTR_MAX);
          hi = $urandom_range(0, lo);
          issue((pick == 8) ? CMD_CRACK2 : CMD_CRACK3, $urandom_range(0, ROWS - 1),
                $urandom_range(0, COLUMNS - 1), $urandom, $urandom, lo, hi, $urandom, $urandom);
        end
      end
    end

    drain();
    repeat (16) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.pending_splits.size() == 0)
      $display("column_crack_partition regression: pass");
    else
      $display("column_crack_partition regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
